// ===== src/etl_pkg.sv =====
// Package for the euclidean tour length unit: field widths, command codes
// and the controller state type. No dependencies.
`timescale 1ns / 1ps

package etl_pkg;

   localparam int INDEX_W       = 10;  // node_index field
   localparam int COORD_FIELD_W = 16;  // coord_x / coord_y fields
   localparam int TOUR_W        = 36;  // tour_length field and running sum

   localparam logic CMD_WRITE = 1'b0;  // load node coordinates
   localparam logic CMD_VISIT = 1'b1;  // next node of the path

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_ROOT,
      ST_FINISH
   } state_type;

endpackage

// ===== src/euclidean_tour_length_unit.sv =====
// Euclidean tour length unit, top level. Uses etl_pkg, etl_node_table,
// etl_square_sum and etl_sqrt_serial.
// Write transaction: table updated at acceptance, busy stays low (1 per cycle).
// Visit transaction: only the read and finish states for the first node of a
// path; otherwise the bit-serial squarer (COORD_BITS+1 steps) and the
// bit-serial root (COORD_BITS+9 steps) run between them.
// Result strobe comes the cycle busy drops; receiver cannot stall.
// Reset clears control, previous node and sum; table contents undefined.
`timescale 1ns / 1ps

module euclidean_tour_length_unit #(
   parameter int MAX_NODES  = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [etl_pkg::INDEX_W-1:0]         req_node_index,
   input  logic signed [etl_pkg::COORD_FIELD_W-1:0] req_coord_x,
   input  logic signed [etl_pkg::COORD_FIELD_W-1:0] req_coord_y,
   input  logic                                req_path_end,
   output logic                                rsp_valid,
   output logic [etl_pkg::TOUR_W-1:0]          rsp_tour_length
);

   localparam int CB = COORD_BITS;
   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int XW = (AW > etl_pkg::INDEX_W) ? AW : etl_pkg::INDEX_W;
   localparam int MW = CB + 1;        // |dx| up to 2^CB - 1
   localparam int SW = 2 * CB + 2;    // dx^2 + dy^2 below 2^(2CB+1)
   localparam int RW = SW / 2 + 8;    // root bits, 8 of them fraction
   localparam int TW = etl_pkg::TOUR_W;

   // ---------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------
   logic          accept;
   logic [XW-1:0] idx_ext;
   logic [AW-1:0] addr;
   logic          in_range;
   logic [CB-1:0] wr_x, wr_y;

   assign accept   = start && !busy;
   assign idx_ext  = XW'(req_node_index);
   assign addr     = idx_ext[AW-1:0];
   assign in_range = 32'(req_node_index) < 32'(MAX_NODES);
   // sign-extend then keep CB bits (wraps when CB < field width)
   assign wr_x     = CB'(req_coord_x);
   assign wr_y     = CB'(req_coord_y);

   logic [2*CB-1:0] rd_data;

   etl_node_table #(
      .DEPTH (MAX_NODES),
      .AW    (AW),
      .DW    (2 * CB)
   ) u_table (
      .clock   (clock),
      .wr_en   (accept && req_command == etl_pkg::CMD_WRITE && in_range),
      .wr_addr (addr),
      .wr_data ({wr_x, wr_y}),
      .rd_en   (accept && req_command == etl_pkg::CMD_VISIT),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------
   // Controller state
   // ---------------------------------------------------------------
   etl_pkg::state_type state_ff, state_in;
   logic                 end_ff, end_in;
   logic                 in_range_ff, in_range_in;
   logic                 have_prev_ff, have_prev_in;
   logic signed [CB-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CB-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [TW-1:0]        sum_ff, sum_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]        rsp_len_ff, rsp_len_in;

   // Node just read; an out-of-range visit reads as the origin.
   logic signed [CB-1:0] cur_x, cur_y;
   logic signed [CB:0]   dx, dy;
   logic [MW-1:0]        mag_x, mag_y;

   assign cur_x = in_range_ff ? signed'(rd_data[2*CB-1:CB]) : '0;
   assign cur_y = in_range_ff ? signed'(rd_data[CB-1:0])    : '0;
   assign dx    = (CB + 1)'(prev_x_ff) - (CB + 1)'(cur_x);
   assign dy    = (CB + 1)'(prev_y_ff) - (CB + 1)'(cur_y);
   // negation of the most negative difference, 1 - 2^CB, fits in CB+1 unsigned bits
   assign mag_x = dx[CB] ? unsigned'(-dx) : unsigned'(dx);
   assign mag_y = dy[CB] ? unsigned'(-dy) : unsigned'(dy);

   // ---------------------------------------------------------------
   // Arithmetic units
   // ---------------------------------------------------------------
   logic          sq_load, sq_done;
   logic [SW-1:0] sq_sum;
   logic          rt_load, rt_done;
   logic [RW-1:0] rt_root;

   etl_square_sum #(
      .MW (MW),
      .SW (SW)
   ) u_square (
      .clock (clock),
      .reset (reset),
      .load  (sq_load),
      .mag_a (mag_x),
      .mag_b (mag_y),
      .done  (sq_done),
      .sum   (sq_sum)
   );

   etl_sqrt_serial #(
      .SW (SW),
      .RW (RW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .load     (rt_load),
      .radicand (sq_sum),
      .done     (rt_done),
      .root     (rt_root)
   );

   // saturating accumulate of the new distance
   logic [TW:0] sum_wide;
   assign sum_wide = {1'b0, sum_ff} + (TW + 1)'(rt_root);

   // ---------------------------------------------------------------
   // Next state and datapath control
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      end_in       = end_ff;
      in_range_in  = in_range_ff;
      have_prev_in = have_prev_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      sum_in       = sum_ff;
      rsp_valid_in = 1'b0;
      rsp_len_in   = rsp_len_ff;
      sq_load      = 1'b0;
      rt_load      = 1'b0;
      unique case (state_ff)
         etl_pkg::ST_IDLE: begin
            if (accept && req_command == etl_pkg::CMD_VISIT) begin
               end_in      = req_path_end;
               in_range_in = in_range;
               state_in    = etl_pkg::ST_READ;
            end
         end
         etl_pkg::ST_READ: begin
            cur_x_in = cur_x;
            cur_y_in = cur_y;
            if (have_prev_ff) begin
               sq_load  = 1'b1;
               state_in = etl_pkg::ST_SQUARE;
            end else begin
               state_in = etl_pkg::ST_FINISH;
            end
         end
         etl_pkg::ST_SQUARE: begin
            if (sq_done) begin
               rt_load  = 1'b1;
               state_in = etl_pkg::ST_ROOT;
            end
         end
         etl_pkg::ST_ROOT: begin
            if (rt_done) begin
               sum_in   = sum_wide[TW] ? '1 : sum_wide[TW-1:0];
               state_in = etl_pkg::ST_FINISH;
            end
         end
         etl_pkg::ST_FINISH: begin
            if (end_ff) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = sum_ff;
               sum_in       = '0;
               have_prev_in = 1'b0;
               prev_x_in    = '0;
               prev_y_in    = '0;
            end else begin
               have_prev_in = 1'b1;
               prev_x_in    = cur_x_ff;
               prev_y_in    = cur_y_ff;
            end
            state_in = etl_pkg::ST_IDLE;
         end
         default: begin
            state_in = etl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etl_pkg::ST_IDLE;
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      end_ff      <= end_in;
      in_range_ff <= in_range_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign busy            = (state_ff != etl_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tour_length = rsp_len_ff;

endmodule

// ===== src/etl_node_table.sv =====
// Node coordinate table: one write port, one registered read port.
// No package dependency.
`timescale 1ns / 1ps

module etl_node_table #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/etl_square_sum.sv =====
// Bit-serial dx*dx + dy*dy: one multiplier bit of each lane per cycle.
// No package dependency.
`timescale 1ns / 1ps

module etl_square_sum #(
   parameter int MW = 17,   // magnitude width
   parameter int SW = 34    // sum width
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic [MW-1:0] mag_a,
   input  logic [MW-1:0] mag_b,
   output logic          done,
   output logic [SW-1:0] sum
);

   localparam int CW = $clog2(MW + 1);

   logic [SW-1:0] a_ff, a_in, b_ff, b_in;
   logic [MW-1:0] am_ff, am_in, bm_ff, bm_in;
   logic [SW-1:0] acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      am_in   = am_ff;
      bm_in   = bm_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         a_in   = SW'(mag_a);
         b_in   = SW'(mag_b);
         am_in  = mag_a;
         bm_in  = mag_b;
         acc_in = '0;
         cnt_in = CW'(MW);
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = acc_ff + (am_ff[0] ? a_ff : '0) + (bm_ff[0] ? b_ff : '0);
         a_in   = {a_ff[SW-2:0], 1'b0};
         b_in   = {b_ff[SW-2:0], 1'b0};
         am_in  = {1'b0, am_ff[MW-1:1]};
         bm_in  = {1'b0, bm_ff[MW-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      am_ff  <= am_in;
      bm_ff  <= bm_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

// ===== src/etl_sqrt_serial.sv =====
// Restoring integer square root, one root bit per cycle; the radicand is
// followed by eight zero digit pairs (8 fraction bits). No package dependency.
`timescale 1ns / 1ps

module etl_sqrt_serial #(
   parameter int SW = 34,   // radicand width, even
   parameter int RW = 25    // root width = SW/2 + 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic [SW-1:0] radicand,
   output logic          done,
   output logic [RW-1:0] root
);

   localparam int CW   = $clog2(RW + 1);
   localparam int REMW = RW + 2;

   logic [SW-1:0]   rad_ff, rad_in;
   logic [REMW-1:0] rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [REMW+1:0] rem_sh, trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, rad_ff[SW-1:SW-2]};
      trial   = (REMW + 2)'({root_ff, 2'b01});
      if (load) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(RW);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in = {rad_ff[SW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REMW'(rem_sh - trial);
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = REMW'(rem_sh);
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== sim/etl_tour_checker.sv =====
// Checker for the euclidean tour length unit: watches both channels, predicts tour totals
// and compares them with the result strobes. Depends on etl_pkg.
`timescale 1ns / 1ps

module etl_tour_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic                                     busy,
   input  logic                                     req_command,
   input  logic [etl_pkg::INDEX_W-1:0]              req_node_index,
   input  logic signed [etl_pkg::COORD_FIELD_W-1:0] req_coord_x,
   input  logic signed [etl_pkg::COORD_FIELD_W-1:0] req_coord_y,
   input  logic                                     req_path_end,
   input  logic                                     rsp_valid,
   input  logic [etl_pkg::TOUR_W-1:0]               rsp_tour_length,
   output int                                       fail_count,
   output int                                       pending_results
);

   localparam int NODE_COUNT = 1 << etl_pkg::INDEX_W;

   // table mirror; entries never read before written
   logic signed [etl_pkg::COORD_FIELD_W-1:0] node_x [NODE_COUNT];
   logic signed [etl_pkg::COORD_FIELD_W-1:0] node_y [NODE_COUNT];
   logic signed [etl_pkg::COORD_FIELD_W-1:0] last_x, last_y;
   logic signed [etl_pkg::COORD_FIELD_W-1:0] here_x, here_y;
   logic                                     path_open;
   logic [etl_pkg::TOUR_W-1:0]               run_sum;
   logic [etl_pkg::TOUR_W-1:0]               tour_due_q [$];
   logic [etl_pkg::TOUR_W-1:0]               tour_due;

   initial begin
      fail_count      = 0;
      pending_results = 0;
   end

   task automatic report_mismatch(input string what, input logic [etl_pkg::TOUR_W-1:0] got,
                                  input logic [etl_pkg::TOUR_W-1:0] want);
      $display("%0t ns: tour_length %s: got %0d, want %0d", $time, what, got, want);
      fail_count++;
   endtask

   // floor(sqrt((dx^2 + dy^2) * 2^16)), 8 fraction bits
   function automatic logic [etl_pkg::TOUR_W-1:0] leg_length(
         input logic signed [etl_pkg::COORD_FIELD_W-1:0] ax, ay, bx, by);
      logic signed [etl_pkg::COORD_FIELD_W:0] dx, dy;
      logic [etl_pkg::COORD_FIELD_W:0]        mx, my;
      logic [63:0]                            rest, root, probe;
      dx    = $signed({ax[etl_pkg::COORD_FIELD_W-1], ax}) -
              $signed({bx[etl_pkg::COORD_FIELD_W-1], bx});
      dy    = $signed({ay[etl_pkg::COORD_FIELD_W-1], ay}) -
              $signed({by[etl_pkg::COORD_FIELD_W-1], by});
      mx    = dx[etl_pkg::COORD_FIELD_W] ? -dx : dx;
      my    = dy[etl_pkg::COORD_FIELD_W] ? -dy : dy;
      rest  = (64'(mx) * 64'(mx) + 64'(my) * 64'(my)) << 16;
      root  = 64'd0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > rest)
         probe = probe >> 2;
      while (probe != 64'd0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[etl_pkg::TOUR_W-1:0];
   endfunction

   function automatic logic [etl_pkg::TOUR_W-1:0] add_saturating(
         input logic [etl_pkg::TOUR_W-1:0] a, b);
      logic [etl_pkg::TOUR_W:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[etl_pkg::TOUR_W] ? '1 : total[etl_pkg::TOUR_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         tour_due_q.delete();
         path_open       = 1'b0;
         run_sum         = '0;
         last_x          = '0;
         last_y          = '0;
         pending_results <= 0;
      end else begin
         // a result always belongs to an earlier transaction: check before predicting
         if (rsp_valid) begin
            if (tour_due_q.size() == 0) begin
               report_mismatch("strobe with nothing outstanding", rsp_tour_length, '0);
            end else begin
               tour_due = tour_due_q.pop_front();
               if (rsp_tour_length !== tour_due)
                  report_mismatch("mismatch", rsp_tour_length, tour_due);
            end
         end
         if (start && !busy) begin
            if (req_command == etl_pkg::CMD_WRITE) begin
               node_x[req_node_index] = req_coord_x;
               node_y[req_node_index] = req_coord_y;
            end else begin
               here_x = node_x[req_node_index];
               here_y = node_y[req_node_index];
               if (path_open)
                  run_sum = add_saturating(run_sum, leg_length(last_x, last_y, here_x, here_y));
               if (req_path_end) begin
                  tour_due_q.push_back(run_sum);
                  run_sum   = '0;
                  path_open = 1'b0;
                  last_x    = '0;
                  last_y    = '0;
               end else begin
                  last_x    = here_x;
                  last_y    = here_y;
                  path_open = 1'b1;
               end
            end
         end
         pending_results <= tour_due_q.size();
      end
   end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the euclidean tour length unit: clock, reset, node loads and path
// stimulus, verdict. Depends on etl_pkg, euclidean_tour_length_unit and etl_tour_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam int IW          = etl_pkg::INDEX_W;
   localparam int NODE_COUNT  = 1 << etl_pkg::INDEX_W;
   localparam int PHASE_ITEMS = 325;   // four random phases, about 1300 transactions
   localparam int TAIL_CYCLES = 60;    // extra wait after the final drain, before the verdict

   // every input known from time zero
   logic                                     clock          = 1'b0;
   logic                                     reset          = 1'b1;
   logic                                     start          = 1'b0;
   logic                                     req_command    = etl_pkg::CMD_WRITE;
   logic [etl_pkg::INDEX_W-1:0]              req_node_index = '0;
   logic signed [etl_pkg::COORD_FIELD_W-1:0] req_coord_x    = '0;
   logic signed [etl_pkg::COORD_FIELD_W-1:0] req_coord_y    = '0;
   logic                                     req_path_end   = 1'b0;
   logic                                     busy;
   logic                                     rsp_valid;
   logic [etl_pkg::TOUR_W-1:0]               rsp_tour_length;
   int                                       fail_count;
   int                                       pending_results;

   // sender idle odds per cycle, in percent; set per phase
   int unsigned idle_pct = 0;

   // only nodes already loaded are ever visited (unwritten entries are undefined)
   bit          loaded [NODE_COUNT];
   int unsigned loaded_q [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   euclidean_tour_length_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_node_index  (req_node_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_path_end    (req_path_end),
      .rsp_valid       (rsp_valid),
      .rsp_tour_length (rsp_tour_length)
   );

   etl_tour_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_node_index  (req_node_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_path_end    (req_path_end),
      .rsp_valid       (rsp_valid),
      .rsp_tour_length (rsp_tour_length),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // One transaction. Random idle cycles come first, so gaps land on whatever the
   // block is doing at the time. Returns on the edge that accepts it; the caller
   // drives the next transaction (or drops start) in that same step, so start is
   // never lowered and raised within one step.
   task automatic send_item(input logic cmd, input logic [etl_pkg::INDEX_W-1:0] idx,
                            input logic signed [etl_pkg::COORD_FIELD_W-1:0] cx, cy,
                            input logic last);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_command    <= cmd;
      req_node_index <= idx;
      req_coord_x    <= cx;
      req_coord_y    <= cy;
      req_path_end   <= last;
      // busy read here is the value before the edge, so this edge is the acceptance
      do @(posedge clock); while (busy);
      if (cmd == etl_pkg::CMD_WRITE && !loaded[idx]) begin
         loaded[idx] = 1'b1;
         loaded_q.push_back(32'(idx));
      end
   endtask

   // Sender holds off until every outstanding total has come back and the block is idle.
   // do-while: at least one edge passes so the checker's count covers the last transaction.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_results != 0 || busy);
   endtask

   // corners and values near zero are weighted up; the rest is uniform over all 16 bits
   function automatic logic signed [etl_pkg::COORD_FIELD_W-1:0] rand_coord();
      case ($urandom_range(5))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return $signed(16'($urandom_range(8))) - 16'sd4;
         default: return $signed(16'($urandom()));
      endcase
   endfunction

   function automatic logic [etl_pkg::INDEX_W-1:0] pick_loaded();
      return IW'(loaded_q[$urandom_range(loaded_q.size() - 1)]);
   endfunction

   // Mostly whole paths over loaded nodes with path_end on the last visit; the rest
   // are loads (path_end set at random, so the ignored case is hit) and stray visits
   // that may leave a path open for the next one to continue.
   task automatic run_random(input int unsigned count);
      int unsigned done;
      int unsigned hops;
      int unsigned pick;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            send_item(etl_pkg::CMD_WRITE, IW'($urandom_range(NODE_COUNT - 1)), rand_coord(),
                      rand_coord(), 1'($urandom_range(1)));
            done++;
         end else if (pick < 26) begin
            send_item(etl_pkg::CMD_VISIT, pick_loaded(), rand_coord(), rand_coord(),
                      1'($urandom_range(1)));
            done++;
         end else begin
            hops = ($urandom_range(19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int unsigned k = 0; k < hops; k++)
               send_item(etl_pkg::CMD_VISIT, pick_loaded(), rand_coord(), rand_coord(),
                         k == hops - 1);
            done += hops;
         end
      end
   endtask

   initial begin
      int unsigned phase_idle [4];
      phase_idle = '{87, 0, 11, 87};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: table corners, a 3-4-5 leg, one-node path, longest leg,
      // zero-length leg, overwrite of a node, path_end on a load (ignored)
      send_item(etl_pkg::CMD_WRITE, 10'd0,    16'sh8000, 16'sh8000, 1'b1);
      send_item(etl_pkg::CMD_WRITE, 10'd1023, 16'sh7fff, 16'sh7fff, 1'b0);
      send_item(etl_pkg::CMD_WRITE, 10'd1,    16'sd0,    16'sd0,    1'b0);
      send_item(etl_pkg::CMD_WRITE, 10'd2,    16'sd3,    16'sd4,    1'b0);
      send_item(etl_pkg::CMD_WRITE, 10'd512,  -16'sd1,   16'sd1,    1'b0);
      send_item(etl_pkg::CMD_VISIT, 10'd0,    16'sh7fff, 16'sh8000, 1'b1);
      send_item(etl_pkg::CMD_VISIT, 10'd0,    16'sd0,    16'sd0,    1'b0);
      send_item(etl_pkg::CMD_VISIT, 10'd1023, 16'sd0,    16'sd0,    1'b1);
      send_item(etl_pkg::CMD_VISIT, 10'd1,    16'sd0,    16'sd0,    1'b0);
      send_item(etl_pkg::CMD_VISIT, 10'd1,    16'sd0,    16'sd0,    1'b0);
      send_item(etl_pkg::CMD_VISIT, 10'd2,    16'sd0,    16'sd0,    1'b1);
      send_item(etl_pkg::CMD_VISIT, 10'd1023, 16'sd0,    16'sd0,    1'b0);
      send_item(etl_pkg::CMD_VISIT, 10'd0,    16'sd0,    16'sd0,    1'b0);
      send_item(etl_pkg::CMD_VISIT, 10'd1023, 16'sd0,    16'sd0,    1'b1);
      send_item(etl_pkg::CMD_VISIT, 10'd512,  16'sd0,    16'sd0,    1'b0);
      send_item(etl_pkg::CMD_VISIT, 10'd2,    16'sd0,    16'sd0,    1'b1);
      send_item(etl_pkg::CMD_WRITE, 10'd2,    16'sh7fff, 16'sh8000, 1'b0);
      send_item(etl_pkg::CMD_VISIT, 10'd2,    16'sd0,    16'sd0,    1'b0);
      send_item(etl_pkg::CMD_VISIT, 10'd0,    16'sd0,    16'sd0,    1'b1);
      send_item(etl_pkg::CMD_VISIT, 10'd1023, 16'sd0,    16'sd0,    1'b0);
      send_item(etl_pkg::CMD_VISIT, 10'd512,  16'sd0,    16'sd0,    1'b1);

      // random phases; the drain before each is the sender pause
      foreach (phase_idle[p]) begin
         drain();
         idle_pct = phase_idle[p];
         run_random(PHASE_ITEMS);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS euclidean_tour_length_unit");
      else
         $display("FAIL euclidean_tour_length_unit");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("FAIL euclidean_tour_length_unit");
      $finish;
   end

endmodule

// ===== sim.f =====
src/etl_pkg.sv
src/etl_node_table.sv
src/etl_square_sum.sv
src/etl_sqrt_serial.sv
src/euclidean_tour_length_unit.sv
sim/etl_tour_checker.sv
sim/tb_top.sv
